>>> hw/rtl/spam_pkg.sv
// Shared types, constants and the ray-walking function for the sliding attack generator.
package spam_pkg;

  localparam int BOARD_DIM   = 8;
  localparam int MAX_COORD   = BOARD_DIM - 1;
  localparam int COORD_W     = $clog2(BOARD_DIM);
  localparam int SQUARE_W    = 2 * COORD_W;
  localparam int BOARD_W     = BOARD_DIM * BOARD_DIM;
  localparam int NUM_RAYS    = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    ACT_DIAGONAL   = 1'b0,
    ACT_ORTHOGONAL = 1'b1
  } action_t;

  typedef logic [BOARD_W-1:0] board_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    action_t action;
    coord_t  row;
    coord_t  col;
    board_t  occupancy;
  } query_t;

  // Row and column step of each ray, two-bit signed.
  localparam logic signed [1:0] ORTHO_DR [NUM_RAYS] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] ORTHO_DC [NUM_RAYS] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DIAG_DR  [NUM_RAYS] = '{2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DIAG_DC  [NUM_RAYS] = '{2'sd1, 2'sd1, -2'sd1, -2'sd1};

  // Walks the four rays of the selected set; each ray stops on and includes the first blocker.
  function automatic board_t slide_attacks(query_t q);
    board_t                  acc;
    logic signed [COORD_W+1:0] r;
    logic signed [COORD_W+1:0] c;
    logic signed [1:0]       dr;
    logic signed [1:0]       dc;
    logic                    live;
    logic [SQUARE_W-1:0]     sq;
    acc = '0;
    for (int d = 0; d < NUM_RAYS; d++) begin
      if (q.action == ACT_ORTHOGONAL) begin
        dr = ORTHO_DR[d];
        dc = ORTHO_DC[d];
      end else begin
        dr = DIAG_DR[d];
        dc = DIAG_DC[d];
      end
      r    = {2'b00, q.row};
      c    = {2'b00, q.col};
      live = 1'b1;
      for (int s = 0; s < MAX_COORD; s++) begin
        r  = r + {{COORD_W{dr[1]}}, dr};
        c  = c + {{COORD_W{dc[1]}}, dc};
        sq = {r[COORD_W-1:0], c[COORD_W-1:0]};
        if (live && (r >= 0) && (r <= MAX_COORD) && (c >= 0) && (c <= MAX_COORD)) begin
          acc[sq] = 1'b1;
          if (q.occupancy[sq]) begin
            live = 1'b0;
          end
        end else begin
          live = 1'b0;
        end
      end
    end
    return acc;
  endfunction

endpackage

>>> hw/rtl/spam_front.sv
// Front stage: takes query beats and splits the square into row and column.
module spam_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [5:0]               origin_square,
  input  logic [63:0]              occupancy,
  output logic                     push_valid,
  input  logic                     push_ready,
  output spam_pkg::query_t         push_entry
);
  import spam_pkg::*;

  logic   held_valid;
  query_t held;
  query_t held_next;

  assign in_stall   = held_valid && !push_ready;
  assign push_valid = held_valid;
  assign push_entry = held;

  always_comb begin
    held_next.action    = action_t'(action);
    held_next.row       = origin_square[SQUARE_W-1:COORD_W];
    held_next.col       = origin_square[COORD_W-1:0];
    held_next.occupancy = occupancy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held <= held_next;
    end
  end

  a_hold_while_blocked: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !push_ready) |=> (held_valid && $stable(held)))
    else $error("front entry changed while the queue was full");

endmodule

>>> hw/rtl/spam_queue.sv
// Small FIFO of classified queries between the front and back stages.
module spam_queue #(
  parameter int DEPTH = spam_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  spam_pkg::query_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output spam_pkg::query_t pop_entry
);
  import spam_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  query_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptrs_match_when_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");

endmodule

>>> hw/rtl/spam_back.sv
// Back stage: resolves the four rays of a queued query into a registered attack board.
module spam_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  spam_pkg::query_t pop_entry,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      attack_board
);
  import spam_pkg::*;

  board_t attack_next;

  assign pop_ready   = !out_valid || !out_stall;
  assign attack_next = slide_attacks(pop_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      attack_board <= attack_next;
    end
  end

  a_never_self: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> !attack_board[$past({pop_entry.row, pop_entry.col})])
    else $error("origin square appears in the attack board");

endmodule

>>> hw/rtl/sliding_piece_attack_mask.sv
// Top level of the sliding-piece attack generator: front, queue and back stages.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  query   | in        | in_valid/in_stall | action, origin_square[5:0], occupancy[63:0]
//  attack  | out       | out_valid/out_stall | attack_board[63:0]
//
// One query beat is taken every clock cycle while in_stall is low. A query is registered in
// the front register, then written into a queue slot, and its attack board is registered in
// the output register, which presents the attack beat.
// The ray walk is a fixed chain of seven squares per ray, resolved in the back stage
// between the queue read and the output register.
// Reset (rst, synchronous) empties the front register, the queue and the output register.
// A stall on the attack side fills the queue first; the query side stalls only once the
// queue is full and the front register holds a beat.
module sliding_piece_attack_mask #(
  parameter int QUEUE_DEPTH = spam_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [5:0]  origin_square,
  input  logic [63:0] occupancy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] attack_board
);
  import spam_pkg::*;

  // Front to queue.
  logic   push_valid;
  logic   push_ready;
  query_t push_entry;

  // Queue to back.
  logic   pop_valid;
  logic   pop_ready;
  query_t pop_entry;

  // The front stage registers each beat with the square split into row and column.
  spam_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .origin_square (origin_square),
    .occupancy     (occupancy),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // The queue decouples the two sides so a stall downstream does not reach the input
  // until every slot is taken.
  spam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // The back stage walks the rays and holds the result until it is taken.
  spam_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .attack_board (attack_board)
  );

endmodule

>>> tb/sv/attack_checker.sv
// Checker for the sliding attack generator: predicts each attack board and compares.
`timescale 1ns / 1ps

module attack_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [5:0]  origin_square,
  input  logic [63:0] occupancy,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] attack_board,
  output int          fail_count,
  output int          pending
);
  import spam_pkg::*;

  logic [63:0] expected_boards[$];
  int          mismatches = 0;

  // Walks the four rays of the chosen set from the origin; a ray ends on its first blocker.
  function automatic logic [63:0] predict_attacks(action_t act, logic [5:0] sq,
                                                  logic [63:0] occ);
    logic [63:0] board;
    int          row;
    int          col;
    int          r;
    int          c;
    int          dr;
    int          dc;
    int          idx;
    bit          live;
    board = '0;
    row   = sq / 8;
    col   = sq % 8;
    for (int ray = 0; ray < 4; ray++) begin
      if (act == ACT_ORTHOGONAL) begin
        case (ray)
          0: begin dr = 1;  dc = 0;  end
          1: begin dr = -1; dc = 0;  end
          2: begin dr = 0;  dc = 1;  end
          default: begin dr = 0; dc = -1; end
        endcase
      end else begin
        dr = (ray % 2 == 0) ? 1 : -1;
        dc = (ray < 2) ? 1 : -1;
      end
      r    = row + dr;
      c    = col + dc;
      live = 1'b1;
      while (live && r >= 0 && r <= 7 && c >= 0 && c <= 7) begin
        idx        = r * 8 + c;
        board[idx] = 1'b1;
        if (occ[idx]) begin
          live = 1'b0;
        end
        r = r + dr;
        c = c + dc;
      end
    end
    return board;
  endfunction

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      // Results are compared before this edge's query is queued, so a beat can never be
      // matched against its own prediction.
      if (out_valid && !out_stall) begin
        if (expected_boards.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Unexpected attack beat: actual %h", attack_board);
          end
        end else begin
          want = expected_boards.pop_front();
          if (attack_board !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("Attack board mismatch: expected %h actual %h", want, attack_board);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_boards.push_back(predict_attacks(action_t'(action), origin_square,
                                                  occupancy));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_boards.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the testbench: clock, reset, query stimulus, attack-side stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import spam_pkg::*;

  // The watchdog fires after this many cycles in a row with no beat on either channel.
  // The longest correct pause is a long sender gap plus a long receiver stall plus the time
  // through the front register, the queue and the output register, well below the limit.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1800;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        action        = ACT_DIAGONAL;
  logic [5:0]  origin_square = '0;
  logic [63:0] occupancy     = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [63:0] attack_board;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // While set, neither side inserts gaps, so the pipeline runs at full rate.
  bit quiet = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sliding_piece_attack_mask dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .origin_square(origin_square),
    .occupancy    (occupancy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .attack_board (attack_board)
  );

  attack_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .origin_square(origin_square),
    .occupancy    (occupancy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .attack_board (attack_board),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Length of an idle stretch: mostly none or a few cycles, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // Occupancy with varied density, so rays end early, late, or run to the edge.
  function automatic logic [63:0] random_board();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return a & b & {$urandom, $urandom};
      4, 5:    return a & b;
      6:       return a | b;
      default: return a;
    endcase
  endfunction

  // Presents one query beat after an optional gap and holds it until it is taken.
  task automatic send_query(input action_t act, input logic [5:0] sq, input logic [63:0] occ);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    origin_square <= sq;
    occupancy     <= occ;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // The attack side alternates between taking beats and stalling for random spans.
  initial begin
    int span;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      span = idle_len();
      if (span > 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: any accepted beat on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [5:0] corners[5];
    action_t    act;
    corners = '{6'd0, 6'd7, 6'd56, 6'd63, 6'd27};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Corners and a center square on an empty board give the longest rays
    // and the ones cut short by the edges, for both ray sets.
    for (int i = 0; i < 5; i++) begin
      send_query(ACT_DIAGONAL, corners[i], '0);
      send_query(ACT_ORTHOGONAL, corners[i], '0);
    end
    // A full board stops every ray on its first square.
    send_query(ACT_DIAGONAL, 6'd36, '1);
    send_query(ACT_ORTHOGONAL, 6'd36, '1);
    // Only the origin itself is occupied: its bit must be ignored and never set.
    send_query(ACT_DIAGONAL, 6'd36, 64'd1 << 36);
    send_query(ACT_ORTHOGONAL, 6'd36, 64'd1 << 36);
    // Every square but the origin is occupied, on an inner square and on an edge square.
    send_query(ACT_DIAGONAL, 6'd9, ~(64'd1 << 9));
    send_query(ACT_ORTHOGONAL, 6'd15, ~(64'd1 << 15));
    // Blockers sitting directly on the board edge, against an alternating pattern.
    send_query(ACT_ORTHOGONAL, 6'd0, 64'h8000_0000_0000_0080);
    send_query(ACT_DIAGONAL, 6'd0, 64'h8000_0000_0000_0000);
    send_query(ACT_ORTHOGONAL, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
    send_query(ACT_DIAGONAL, 6'd63, 64'h5555_5555_5555_5555);

    // Random part. Every few hundred beats a stretch runs with no gaps on either side.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i % 400) >= 330;
      act   = action_t'($urandom_range(0, 1));
      send_query(act, 6'($urandom_range(0, 63)), random_board());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait until every predicted board has come back, then a few more cycles so a
    // stray beat from the pipeline would still be caught.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/spam_pkg.sv
hw/rtl/spam_front.sv
hw/rtl/spam_queue.sv
hw/rtl/spam_back.sv
hw/rtl/sliding_piece_attack_mask.sv
tb/sv/attack_checker.sv
tb/sv/tb_top.sv
